>>> design/lkv_pkg.sv
// Package: widths, command codes, FSM states and cell types for the LRU key/value cache.
`default_nettype none
package lkv_pkg;

  localparam int MaxEntries = 16;
  localparam int KeyW       = 16;
  localparam int ValW       = 32;
  localparam int CapW       = 5;
  localparam int CntW       = $clog2(MaxEntries + 1);
  localparam int CmpW       = (CntW > CapW) ? CntW : CapW;

  localparam logic [CapW-1:0] CapReset = 5'd16;

  typedef enum logic {
    CMD_GET = 1'b0,
    CMD_PUT = 1'b1
  } cmd_e;

  typedef enum logic {
    S_IDLE   = 1'b0,
    S_UPDATE = 1'b1
  } state_e;

  typedef struct packed {
    logic            valid;
    logic [KeyW-1:0] key;
    logic [ValW-1:0] value;
  } cell_word_t;

  typedef struct packed {
    logic en;     // apply cycle
    logic shift;  // take neighbor's word
    logic keep;   // position lies below the new fill
  } cell_ctrl_t;

endpackage
`default_nettype wire

>>> design/lru_key_value_cache.sv
// Top level: LRU key/value cache built as a recency-ordered chain of cells.
// The accepted word is registered; compare+shift over the chain and the result register load
// follow in S_UPDATE once the output register is free. No new word is taken until then.
// The next input word is taken while a finished result still waits in the output register.
// Reset (async, active low): cache empty, capacity 16, no result pending; no clearing pass.
`default_nettype none
module lru_key_value_cache
  import lkv_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            in_valid_i,
  output logic                 in_ready_o,
  input  wire logic            command_i,
  input  wire logic [KeyW-1:0] key_i,
  input  wire logic [ValW-1:0] value_i,
  output logic                 out_valid_o,
  input  wire logic            out_ready_i,
  output logic                 hit_o,
  output logic [ValW-1:0]      read_value_o,
  input  wire logic            cfg_valid_i,
  output logic                 cfg_ready_o,
  input  wire logic [CapW-1:0] cfg_data_i
);

  state_e          state_q, state_d;
  logic [CapW-1:0] cap_q;
  logic [CntW-1:0] count_q, count_d;
  logic            cmd_q;
  logic [KeyW-1:0] key_q;
  logic [ValW-1:0] value_q;
  logic            out_valid_q, out_valid_d;
  logic            hit_q;
  logic [ValW-1:0] rdata_q;

  logic                  apply;
  logic [MaxEntries-1:0] match_vec;
  logic [MaxEntries-1:0] valid_vec;
  logic                  any_hit;
  logic [ValW-1:0]       hit_value;
  logic [CmpW-1:0]       eff_cap, kept, limit;
  cell_word_t            head;
  cell_word_t            cell_word [MaxEntries];
  cell_ctrl_t            cell_ctrl [MaxEntries];

  assign in_ready_o   = (state_q == S_IDLE);
  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign read_value_o = rdata_q;
  assign apply        = (state_q == S_UPDATE) && (!out_valid_q || out_ready_i);
  assign any_hit      = |match_vec;

  always_comb begin
    hit_value = '0;
    for (int i = 0; i < MaxEntries; i++) begin
      hit_value = hit_value | (cell_word[i].value & {ValW{match_vec[i]}});
    end
  end

  always_comb begin
    if (cap_q == '0) begin
      eff_cap = CmpW'(1);
    end else if (CmpW'(cap_q) > CmpW'(MaxEntries)) begin
      eff_cap = CmpW'(MaxEntries);
    end else begin
      eff_cap = CmpW'(cap_q);
    end
    kept  = (CmpW'(count_q) < eff_cap) ? CmpW'(count_q) : eff_cap - CmpW'(1);
    limit = any_hit ? CmpW'(count_q) : kept + CmpW'(1);
  end

  always_comb begin
    head.valid = 1'b1;
    head.key   = key_q;
    head.value = (cmd_q == CMD_PUT) ? value_q : hit_value;
  end

  // a hit rotates positions up to the match; a put miss shifts the whole row; a get miss changes nothing
  always_comb begin
    for (int i = 0; i < MaxEntries; i++) begin
      cell_ctrl[i].en    = apply && (any_hit || (cmd_q == CMD_PUT));
      cell_ctrl[i].shift = any_hit ? |(match_vec >> i) : 1'b1;
      cell_ctrl[i].keep  = CmpW'(i) < limit;
    end
  end

  for (genvar g = 0; g < MaxEntries; g++) begin : g_cell
    lkv_cell u_cell (
      .clk_i        (clk_i),
      .rst_ni       (rst_ni),
      .lookup_key_i (key_q),
      .ctrl_i       (cell_ctrl[g]),
      .prev_i       ((g == 0) ? head : cell_word[(g == 0) ? 0 : g - 1]),
      .word_o       (cell_word[g]),
      .match_o      (match_vec[g])
    );
    assign valid_vec[g] = cell_word[g].valid;
  end

  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          state_d = S_UPDATE;
        end
      end
      S_UPDATE: begin
        if (apply) begin
          state_d     = S_IDLE;
          out_valid_d = 1'b1;
          if (!any_hit && (cmd_q == CMD_PUT)) begin
            count_d = CntW'(limit);
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      cap_q       <= CapReset;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      out_valid_q <= out_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        cap_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q   <= command_i;
      key_q   <= key_i;
      value_q <= value_i;
    end
    if (apply) begin
      hit_q   <= any_hit;
      rdata_q <= (any_hit && (cmd_q == CMD_GET)) ? hit_value : '0;
    end
  end

  a_match_unique : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(match_vec))
    else $error("key matched in more than one cell");

  a_count_tracks : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(valid_vec) == 32'(count_q))
    else $error("fill count differs from valid cells");

  a_valid_packed : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_vec & (valid_vec + MaxEntries'(1))) == '0)
    else $error("valid cells not packed at the front");

  a_put_fills : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (apply && (cmd_q == CMD_PUT)) |=> (count_q != '0))
    else $error("cache empty after put");

endmodule
`default_nettype wire

>>> design/lkv_cell.sv
// One recency position of the LRU chain: holds a word, compares its key, shifts from its neighbor.
`default_nettype none
module lkv_cell
  import lkv_pkg::*;
(
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic [KeyW-1:0] lookup_key_i,
  input  wire cell_ctrl_t      ctrl_i,
  input  wire cell_word_t      prev_i,
  output cell_word_t           word_o,
  output logic                 match_o
);

  logic            valid_q, valid_d;
  logic [KeyW-1:0] key_q, key_d;
  logic [ValW-1:0] value_q, value_d;

  assign word_o  = '{valid: valid_q, key: key_q, value: value_q};
  assign match_o = valid_q && (key_q == lookup_key_i);

  always_comb begin
    valid_d = valid_q;
    key_d   = key_q;
    value_d = value_q;
    if (ctrl_i.en) begin
      if (ctrl_i.shift) begin
        valid_d = prev_i.valid;
        key_d   = prev_i.key;
        value_d = prev_i.value;
      end
      valid_d = valid_d && ctrl_i.keep;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q   <= key_d;
    value_q <= value_d;
  end

endmodule
`default_nettype wire
